// ----- design/tfd_pkg.sv -----
package tfd_pkg;

  // payload counter width
  localparam int COUNT_BITS = 10;

  // signed width of rows*cols*4+2 for 8-bit signed operands
  localparam int LEN_W = 19;

  localparam int MAX_W      = 10;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;

  localparam logic [MAX_W-1:0] MAX_RESET = MAX_W'(300);

  // largest length a COUNT_BITS counter holds
  localparam logic [LEN_W-2:0] CNT_MAX = (LEN_W-1)'((1 << COUNT_BITS) - 1);

  // sync sequence
  localparam logic [7:0] SYNC_A = 8'h41;
  localparam logic [7:0] SYNC_Q = 8'h71;
  localparam logic [7:0] SYNC_T = 8'h54;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TELE_ENABLE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_FRAME   = CFG_IDX_W'(1);

  // status codes
  localparam logic ST_PAYLOAD  = 1'b0;
  localparam logic ST_REJECTED = 1'b1;

  typedef struct packed {
    logic                  negative;
    logic                  too_long;
    logic [COUNT_BITS-1:0] length;
  } len_info_t;

endpackage

// ----- design/telemetry_frame_deframer_top.sv -----
// a byte that yields a result passes the input stage, then the result register
// throughput: one byte per cycle if no result stalls; else only one more byte can be staged
// input stall rises only when the staged byte is held up by a stalled, full result register
// reset: synchronous, active high; parser hunts for the first sync byte, parsing disabled,
// frame limit 300, held header zero, byte count zero, both stages empty
module telemetry_frame_deframer_top (
  input  logic                           clk,
  input  logic                           rst,
  // configuration write port
  input  logic                           cfg_wr_en,
  input  logic [tfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tfd_pkg::CFG_DATA_W-1:0] cfg_data,
  // byte requests in
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     rx_byte,
  // result requests out
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           status,
  output logic [7:0]                     payload_byte,
  output logic signed [7:0]              row_count,
  output logic signed [7:0]              col_count,
  output logic                           last_of_frame
);
  import tfd_pkg::*;

  // input stage
  logic       stage_valid;
  logic [7:0] stage_byte;
  logic       take;

  // the staged byte leaves whenever the parser takes it; a new request may land the same cycle
  assign in_stall = stage_valid && !take;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!in_stall) begin
      stage_valid <= in_valid;
    end
    if (in_valid && !in_stall) begin
      stage_byte <= rx_byte;
    end
  end

  // sync hunt, header capture, length check, payload count and result register
  tfd_parser u_parser (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .item_valid    (stage_valid),
    .item_byte     (stage_byte),
    .take          (take),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .payload_byte  (payload_byte),
    .row_count     (row_count),
    .col_count     (col_count),
    .last_of_frame (last_of_frame)
  );

endmodule

// ----- design/tfd_len_check.sv -----
module tfd_len_check (
  input  logic signed [7:0]         rows,
  input  logic signed [7:0]         cols,
  input  logic [tfd_pkg::MAX_W-1:0] max_bytes,
  output tfd_pkg::len_info_t        info
);
  import tfd_pkg::*;

  logic signed [15:0]     prod;
  logic signed [LEN_W-1:0] len;
  logic [LEN_W-2:0]        len_mag;

  assign prod    = rows * cols;
  assign len     = (LEN_W'(prod) <<< 2) + LEN_W'(2);
  assign len_mag = len[LEN_W-2:0];

  always_comb begin
    info.negative = len[LEN_W-1];
    info.too_long = !len[LEN_W-1] &&
                    ((len_mag > (LEN_W-1)'(max_bytes)) || (len_mag > CNT_MAX));
    info.length   = len_mag[COUNT_BITS-1:0];
  end

endmodule

// ----- design/tfd_parser.sv -----
module tfd_parser (
  input  logic                           clk,
  input  logic                           rst,
  // configuration
  input  logic                           cfg_wr_en,
  input  logic [tfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tfd_pkg::CFG_DATA_W-1:0] cfg_data,
  // staged byte
  input  logic                           item_valid,
  input  logic [7:0]                     item_byte,
  output logic                           take,
  // result register
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           status,
  output logic [7:0]                     payload_byte,
  output logic signed [7:0]              row_count,
  output logic signed [7:0]              col_count,
  output logic                           last_of_frame
);
  import tfd_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT_A = 3'd0,
    PH_WANT_Q = 3'd1,
    PH_WANT_T = 3'd2,
    PH_ROWS   = 3'd3,
    PH_COLS   = 3'd4,
    PH_DATA   = 3'd5
  } phase_t;

  phase_t                 phase, phase_next;
  logic                   tele_enable;
  logic [MAX_W-1:0]       max_frame_bytes;
  logic [7:0]             held_rows, held_rows_next;
  logic [7:0]             held_cols, held_cols_next;
  logic [COUNT_BITS-1:0]  bytes_left, bytes_left_next;
  logic                   res_valid, res_status, res_last;
  logic [7:0]             res_byte;
  len_info_t              len_info;

  assign take = item_valid && !(out_valid && out_stall);

  tfd_len_check u_len_check (
    .rows      (held_rows),
    .cols      (item_byte),
    .max_bytes (max_frame_bytes),
    .info      (len_info)
  );

  always_comb begin
    phase_next      = PH_HUNT_A;
    held_rows_next  = held_rows;
    held_cols_next  = held_cols;
    bytes_left_next = bytes_left;
    res_valid       = 1'b0;
    res_status      = ST_PAYLOAD;
    res_byte        = 8'd0;
    res_last        = 1'b0;
    if (tele_enable) begin
      case (phase)
        PH_WANT_Q: phase_next = (item_byte == SYNC_Q) ? PH_WANT_T : PH_HUNT_A;
        PH_WANT_T: phase_next = (item_byte == SYNC_T) ? PH_ROWS : PH_HUNT_A;
        PH_ROWS: begin
          held_rows_next = item_byte;
          phase_next     = PH_COLS;
        end
        PH_COLS: begin
          held_cols_next = item_byte;
          if (len_info.negative) begin
            phase_next = PH_HUNT_A;
          end else if (len_info.too_long) begin
            phase_next = PH_HUNT_A;
            res_valid  = 1'b1;
            res_status = ST_REJECTED;
          end else begin
            bytes_left_next = len_info.length;
            phase_next      = PH_DATA;
          end
        end
        PH_DATA: begin
          if (bytes_left != '0) begin
            bytes_left_next = bytes_left - COUNT_BITS'(1);
          end
          res_valid = 1'b1;
          res_byte  = item_byte;
          if (bytes_left <= COUNT_BITS'(1)) begin
            res_last   = 1'b1;
            phase_next = PH_HUNT_A;
          end else begin
            phase_next = PH_DATA;
          end
        end
        default: phase_next = (item_byte == SYNC_A) ? PH_WANT_Q : PH_HUNT_A;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HUNT_A;
      tele_enable     <= 1'b0;
      max_frame_bytes <= MAX_RESET;
      held_rows       <= 8'd0;
      held_cols       <= 8'd0;
      bytes_left      <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (take) begin
        out_valid <= res_valid;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      if (cfg_wr_en) begin
        case (cfg_index)
          REG_TELE_ENABLE: begin
            tele_enable <= cfg_data[0];
            phase       <= PH_HUNT_A;
            bytes_left  <= '0;
            if (cfg_data[0]) begin
              held_rows <= 8'd0;
              held_cols <= 8'd0;
            end
          end
          REG_MAX_FRAME: max_frame_bytes <= cfg_data[MAX_W-1:0];
          default: ;
        endcase
      end else if (take) begin
        phase      <= phase_next;
        held_rows  <= held_rows_next;
        held_cols  <= held_cols_next;
        bytes_left <= bytes_left_next;
      end
    end

    // result payload, no reset needed
    if (take && res_valid) begin
      status        <= res_status;
      payload_byte  <= res_byte;
      row_count     <= held_rows_next;
      col_count     <= held_cols_next;
      last_of_frame <= res_last;
    end
  end

`ifndef SYNTHESIS
  a_data_count_live: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DATA |-> bytes_left != '0)
    else $error("data phase with empty byte count");

  a_reject_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_REJECTED |-> !last_of_frame && payload_byte == 8'd0)
    else $error("rejected result carries payload");

  a_disabled_hunt: assert property (@(posedge clk) disable iff (rst)
    !tele_enable |-> phase == PH_HUNT_A)
    else $error("parser left hunt while disabled");

  a_data_gives_result: assert property (@(posedge clk) disable iff (rst)
    take && tele_enable && phase == PH_DATA |=> out_valid)
    else $error("payload byte produced no result");
`endif

endmodule

// ----- tb/sv/tb_telemetry_frame_deframer_top.sv -----
`timescale 1ns / 100ps

module tb_telemetry_frame_deframer_top;
  import tfd_pkg::*;

  // longest byte count the payload counter can hold
  localparam int COUNT_CAP = (1 << COUNT_BITS) - 1;
  // run limit in clock cycles, far above the slowest legal run
  localparam int CYCLE_LIMIT = 400000;

  // parser phases of the predictor
  typedef enum logic [2:0] {
    HUNT_A, WANT_Q, WANT_T, TAKE_ROWS, TAKE_COLS, TAKE_DATA
  } parse_phase_t;

  // one result request as the block should present it
  typedef struct packed {
    logic              status;
    logic [7:0]        payload;
    logic signed [7:0] rows;
    logic signed [7:0] cols;
    logic              last;
  } deframed_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_TELE_ENABLE;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] rx_byte  = 8'h00;

  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              status;
  logic [7:0]        payload_byte;
  logic signed [7:0] row_count;
  logic signed [7:0] col_count;
  logic              last_of_frame;

  telemetry_frame_deframer_top uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .status        (status),
    .payload_byte  (payload_byte),
    .row_count     (row_count),
    .col_count     (col_count),
    .last_of_frame (last_of_frame)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // bytes waiting to be sent and results the parser still owes
  logic [7:0] rx_stream[$];
  deframed_t  deframed_due[$];

  int  errors      = 0;
  int  cycles      = 0;
  int  phase_bytes = 0;
  // no idling on either side once this is set
  bit  calm        = 1'b0;

  // predictor copy of the parser and its registers
  logic                  pm_enable = 1'b0;
  logic [MAX_W-1:0]      pm_limit  = MAX_RESET;
  parse_phase_t          pm_phase  = HUNT_A;
  logic signed [7:0]     pm_rows   = '0;
  logic signed [7:0]     pm_cols   = '0;
  logic [COUNT_BITS-1:0] pm_left   = '0;

  // payload length announced by a header: rows*cols*4+2, signed
  function automatic int header_len(input logic signed [7:0] r, input logic signed [7:0] c);
    return int'(r) * int'(c) * 4 + 2;
  endfunction

  // advance the predicted parser by one accepted byte, queue any result it owes
  task automatic deframe_byte(input logic [7:0] b);
    int        len;
    deframed_t res;
    if (!pm_enable) begin
      pm_phase = HUNT_A;
      return;
    end
    case (pm_phase)
      WANT_Q: pm_phase = (b == SYNC_Q) ? WANT_T : HUNT_A;
      WANT_T: pm_phase = (b == SYNC_T) ? TAKE_ROWS : HUNT_A;
      TAKE_ROWS: begin
        pm_rows  = b;
        pm_phase = TAKE_COLS;
      end
      TAKE_COLS: begin
        pm_cols  = b;
        len      = header_len(pm_rows, pm_cols);
        pm_phase = HUNT_A;
        // a negative length drops the header without a word
        if (len >= 0) begin
          if (len > int'(pm_limit) || len > COUNT_CAP) begin
            res = '{ST_REJECTED, 8'h00, pm_rows, pm_cols, 1'b0};
            deframed_due.push_back(res);
          end else begin
            pm_left  = len[COUNT_BITS-1:0];
            pm_phase = TAKE_DATA;
          end
        end
      end
      TAKE_DATA: begin
        if (pm_left != 0) pm_left--;
        res = '{ST_PAYLOAD, b, pm_rows, pm_cols, pm_left == 0};
        if (pm_left == 0) pm_phase = HUNT_A;
        deframed_due.push_back(res);
      end
      default: pm_phase = (b == SYNC_A) ? WANT_Q : HUNT_A;
    endcase
  endtask

  // byte driver: takes the next byte from the stream, idles in random bursts
  always @(posedge clk) begin : drive_bytes
    int         send_gap;
    logic       next_valid;
    logic [7:0] next_byte;
    if (rst) begin
      send_gap = 0;
      in_valid <= 1'b0;
    end else begin
      next_valid = in_valid;
      next_byte  = rx_byte;
      // request taken at this edge
      if (in_valid && !in_stall) begin
        deframe_byte(rx_byte);
        next_valid = 1'b0;
      end
      // a held request stays put until it is taken
      if (!next_valid) begin
        if (send_gap != 0) begin
          send_gap--;
        end else if (rx_stream.size() != 0) begin
          if (!calm && $urandom_range(0, 5) == 0) begin
            send_gap = $urandom_range(0, 7);
          end else begin
            next_valid = 1'b1;
            next_byte  = rx_stream.pop_front();
          end
        end
      end
      in_valid <= next_valid;
      rx_byte  <= next_byte;
    end
  end

  task automatic check_field(input string fname, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, fname, want, got);
      errors++;
    end
  endtask

  // result monitor: compares each taken result with the oldest one owed, stalls in bursts
  always @(posedge clk) begin : watch_results
    int        stall_left;
    deframed_t want;
    if (rst) begin
      stall_left = 0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (deframed_due.size() == 0) begin
          $display("%0t ns: result with none owed, expected nothing, actual %0h %0h %0h %0h %0h",
                   $time, status, payload_byte, row_count, col_count, last_of_frame);
          errors++;
        end else begin
          want = deframed_due.pop_front();
          check_field("status", 8'(want.status), 8'(status));
          check_field("payload_byte", want.payload, payload_byte);
          check_field("row_count", want.rows, row_count);
          check_field("col_count", want.cols, col_count);
          check_field("last_of_frame", 8'(want.last), 8'(last_of_frame));
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 7);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // register write, only issued while the parser has nothing in flight
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_TELE_ENABLE) begin
      // any enable write sends the parser back to hunting
      pm_enable = val[0];
      pm_phase  = HUNT_A;
      pm_left   = '0;
      if (val[0]) begin
        pm_rows = '0;
        pm_cols = '0;
      end
    end else begin
      pm_limit = val[MAX_W-1:0];
    end
  endtask

  // sender holds off until every owed result is in and until bytes with no result
  // have cleared both stages
  task automatic settle();
    while (rx_stream.size() != 0 || in_valid || deframed_due.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic push_byte(input logic [7:0] b);
    rx_stream.push_back(b);
    phase_bytes++;
  endtask

  task automatic push_header(input logic signed [7:0] r, input logic signed [7:0] c);
    push_byte(SYNC_A);
    push_byte(SYNC_Q);
    push_byte(SYNC_T);
    push_byte(r);
    push_byte(c);
  endtask

  // whole frame: header plus exactly the payload the current limit lets through
  task automatic push_frame(input logic signed [7:0] r, input logic signed [7:0] c);
    int len;
    push_header(r, c);
    len = header_len(r, c);
    if (len >= 0 && len <= int'(pm_limit) && len <= COUNT_CAP)
      repeat (len) push_byte(8'($urandom_range(0, 255)));
  endtask

  // mostly well-formed frames with random content, the rest noise and broken sync
  task automatic random_traffic(input int budget, input int dim_max);
    logic signed [7:0] r;
    logic signed [7:0] c;
    int                pick;
    phase_bytes = 0;
    while (phase_bytes < budget) begin
      pick = $urandom_range(0, 9);
      if (pick <= 5) begin
        r = 8'($urandom_range(0, dim_max));
        c = 8'($urandom_range(0, dim_max));
        if ($urandom_range(0, 4) == 0) r = -r;
        if ($urandom_range(0, 4) == 0) c = -c;
        push_frame(r, c);
      end else if (pick == 6) begin
        // full-range header, mostly too long or negative
        push_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      end else if (pick == 7) begin
        // sync cut short by a wrong byte
        push_byte(SYNC_A);
        if ($urandom_range(0, 1)) push_byte(SYNC_Q);
        push_byte(8'($urandom_range(0, 255)));
      end else begin
        // noise, leaning on the sync characters
        repeat ($urandom_range(1, 4)) begin
          case ($urandom_range(0, 3))
            0: push_byte(SYNC_A);
            1: push_byte(SYNC_Q);
            2: push_byte(SYNC_T);
            default: push_byte(8'($urandom_range(0, 255)));
          endcase
        end
      end
    end
  endtask

  // stimulus: fills the byte stream phase by phase, registers changed between phases
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // parsing disabled out of reset: a full frame must vanish
    push_frame(1, 1);
    repeat (6) push_byte(8'($urandom_range(0, 255)));
    settle();

    write_reg(REG_TELE_ENABLE, 10'h001);
    // small frame with extreme payload values and sync characters inside
    push_header(1, 1);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(SYNC_A);
    push_byte(SYNC_Q);
    push_byte(8'h55);
    push_byte(8'hAA);
    // zero rows gives the shortest frame
    push_frame(0, 0);
    // negative lengths, dropped
    push_header(-1, 1);
    push_header(-128, 127);
    // too long for the limit and for the counter
    push_header(127, 127);
    push_header(-128, -128);
    // wrong byte after 'A' is consumed, not taken as a new 'A'
    push_byte(SYNC_A);
    push_byte(SYNC_A);
    push_byte(SYNC_Q);
    push_byte(SYNC_T);
    push_byte(8'h01);
    push_byte(8'h01);
    // wrong byte after 'A','q'
    push_byte(SYNC_A);
    push_byte(SYNC_Q);
    push_byte(SYNC_A);
    push_byte(SYNC_Q);
    push_byte(SYNC_T);
    push_byte(8'h00);
    push_byte(8'h00);
    settle();

    // frame cut short by an enable rewrite, upper data bits set
    push_header(1, 1);
    repeat (3) push_byte(8'($urandom_range(0, 255)));
    settle();
    write_reg(REG_TELE_ENABLE, 10'h3FF);
    // parser hunts again, so the rest of the old payload is dropped
    repeat (3) push_byte(8'($urandom_range(0, 255)));
    push_byte(SYNC_A);
    push_byte(SYNC_Q);
    settle();
    // rewrite in the middle of the sync sequence
    write_reg(REG_TELE_ENABLE, 10'h001);
    push_byte(SYNC_T);
    push_byte(8'h01);
    push_byte(8'h01);
    push_frame(0, 1);
    settle();

    // disabled again with stray upper bits
    write_reg(REG_TELE_ENABLE, 10'h2FE);
    push_frame(2, 2);
    settle();
    write_reg(REG_TELE_ENABLE, 10'h001);

    // limits below 2 reject every non-negative length
    write_reg(REG_MAX_FRAME, 10'h000);
    push_frame(0, 0);
    push_header(-2, 3);
    random_traffic(30, 4);
    settle();
    write_reg(REG_MAX_FRAME, 10'd1);
    push_frame(0, 5);
    random_traffic(30, 4);
    settle();
    write_reg(REG_MAX_FRAME, 10'd2);
    push_frame(0, 0);
    push_frame(1, 1);
    random_traffic(30, 4);
    settle();

    // widest limit: a frame longer than the reset limit, headers past the limit
    write_reg(REG_MAX_FRAME, 10'h3FF);
    push_frame(2, 38);
    push_header(16, 16);
    push_header(-16, -16);
    random_traffic(40, 6);
    settle();

    // random limits
    repeat (2) begin
      write_reg(REG_MAX_FRAME, 10'($urandom_range(2, 1023)));
      random_traffic(30, 8);
      settle();
    end

    // back to the reset limit: longest frame under it and the shortest one past it;
    // last stretch runs without idling
    write_reg(REG_MAX_FRAME, MAX_RESET);
    push_frame(2, 37);
    push_header(3, 25);
    random_traffic(30, 6);
    settle();
    calm = 1'b1;
    random_traffic(40, 6);
    settle();

    repeat (10) @(posedge clk);
    if (errors == 0 && deframed_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
